// ===== rtl/cbf_pkg.sv =====
// ----------------------------------------------------------------------------
// cbf_pkg: shared types and constants of the circular buffer FIR filter
// Field widths, operation codes and the control and status bundles between
// the sequencer and the multiply-accumulate unit.
// ----------------------------------------------------------------------------
package cbf_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_DEPTH = 512;
    localparam int COEF_AW    = 9;
    localparam int TAP_W      = 10;
    localparam int PROD_W     = 32;
    localparam int ACC_W      = 41;

    localparam logic [TAP_W-1:0] TAP_RESET = TAP_W'(COEF_DEPTH);

    // Operation codes carried on the input channel.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_PUSH = 1'b1;

    typedef struct packed {
        logic clear;
        logic valid;
    } t_mac_ctrl;

    typedef struct packed {
        logic                    busy;
        logic signed [ACC_W-1:0] acc;
    } t_mac_stat;

endpackage

// ===== rtl/cbf_if.sv =====
// ----------------------------------------------------------------------------
// cbf_if: stream channels of the circular buffer FIR filter
// The input channel carries coefficient loads and sample pushes; the output
// channel carries one filtered value per pushed sample.
// ----------------------------------------------------------------------------
interface cbf_in_if;
    import cbf_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       operation;
    logic [COEF_AW-1:0]         coeff_index;
    logic signed [SAMPLE_W-1:0] coeff_value;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, operation, coeff_index, coeff_value, sample, input ready);
    modport sink   (input valid, operation, coeff_index, coeff_value, sample, output ready);
endinterface

interface cbf_out_if;
    import cbf_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [ACC_W-1:0] filtered;

    modport source (output valid, filtered, input ready);
    modport sink   (input valid, filtered, output ready);
endinterface

// ===== rtl/circular_buffer_fir_filter_unit.sv =====
// ----------------------------------------------------------------------------
// circular_buffer_fir_filter_unit: direct-form FIR filter over a sample ring
// A coefficient load is written straight into the coefficient store. A sample
// push sums taps = min(tap_count, 512) products, one tap per cycle on the
// single shared multiply-accumulate, and shows its result in the output
// register; input ready returns with the result, so a push is taken only
// once the previous one is through. A result that finds the previous one
// still in the output register waits there, and the input waits with it.
// After reset both memories are swept to zero.
// ----------------------------------------------------------------------------
module circular_buffer_fir_filter_unit #(
    parameter int RING_DEPTH = 512
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [cbf_pkg::TAP_W-1:0]   i_cfg_wdata,
    cbf_in_if.sink                      i_in_ch,
    cbf_out_if.source                   o_out_ch
);
    import cbf_pkg::*;

    // Ring address width and the length of the clearing sweep, which must
    // cover the larger of the two memories.
    localparam int RAW     = $clog2(RING_DEPTH);
    localparam int CLR_LEN = (RING_DEPTH > COEF_DEPTH) ? RING_DEPTH : COEF_DEPTH;
    localparam int CLW     = $clog2(CLR_LEN);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN
    } t_state;

    t_state                  r_state,     n_state;
    logic [CLW-1:0]          r_clr_cnt,   n_clr_cnt;
    logic [TAP_W-1:0]        r_tap_count, n_tap_count;
    logic [RAW-1:0]          r_wr_pos,    n_wr_pos;
    logic [RAW-1:0]          r_rd_ptr,    n_rd_ptr;
    logic [TAP_W-1:0]        r_k,         n_k;
    logic [TAP_W-1:0]        r_taps,      n_taps;
    logic                    r_rd_v,      n_rd_v;
    logic                    r_out_valid, n_out_valid;
    logic signed [ACC_W-1:0] r_out_data,  n_out_data;

    logic                    in_beat;
    logic                    push_beat;
    logic                    load_beat;
    logic                    out_beat;
    logic                    issue;
    logic                    done;

    logic                    ring_we;
    logic [RAW-1:0]          ring_waddr;
    logic [SAMPLE_W-1:0]     ring_wdata;
    logic [SAMPLE_W-1:0]     ring_rdata;
    logic                    coef_we;
    logic [COEF_AW-1:0]      coef_waddr;
    logic [SAMPLE_W-1:0]     coef_wdata;
    logic [SAMPLE_W-1:0]     coef_rdata;

    t_mac_ctrl               mac_ctrl;
    t_mac_stat               mac_stat;

    // Items are taken only between pushes; a finished result sits in the
    // output register and does not hold off the next beat.
    assign i_in_ch.ready = (r_state == ST_IDLE);
    assign in_beat       = i_in_ch.valid && i_in_ch.ready;
    assign push_beat     = in_beat && (i_in_ch.operation == OP_PUSH);
    assign load_beat     = in_beat && (i_in_ch.operation == OP_LOAD);
    assign out_beat      = r_out_valid && o_out_ch.ready;

    // One tap read is issued per cycle. The sum is complete once the last
    // read has passed the RAM register and the product register.
    assign issue = (r_state == ST_RUN) && (r_k != r_taps);
    assign done  = (r_state == ST_RUN) && !issue && !r_rd_v && !mac_stat.busy;

    // During the sweep both memories are written with zeros; afterwards the
    // write ports serve sample pushes and coefficient loads.
    always_comb begin
        if (r_state == ST_CLEAR) begin
            ring_we    = 1'b1;
            ring_waddr = r_clr_cnt[RAW-1:0];
            ring_wdata = '0;
            coef_we    = 1'b1;
            coef_waddr = r_clr_cnt[COEF_AW-1:0];
            coef_wdata = '0;
        end else begin
            ring_we    = push_beat;
            ring_waddr = r_wr_pos;
            ring_wdata = i_in_ch.sample;
            coef_we    = load_beat;
            coef_waddr = i_in_ch.coeff_index;
            coef_wdata = i_in_ch.coeff_value;
        end
    end

    cbf_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (ring_waddr),
        .i_wdata (ring_wdata),
        .i_raddr (r_rd_ptr),
        .o_rdata (ring_rdata)
    );

    cbf_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (COEF_DEPTH)
    ) u_coef (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (coef_waddr),
        .i_wdata (coef_wdata),
        .i_raddr (r_k[COEF_AW-1:0]),
        .o_rdata (coef_rdata)
    );

    assign mac_ctrl.clear = push_beat;
    assign mac_ctrl.valid = r_rd_v;

    cbf_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (mac_ctrl),
        .i_sample (ring_rdata),
        .i_coef   (coef_rdata),
        .o_stat   (mac_stat)
    );

    always_comb begin
        n_state     = r_state;
        n_clr_cnt   = r_clr_cnt;
        n_tap_count = r_tap_count;
        n_wr_pos    = r_wr_pos;
        n_rd_ptr    = r_rd_ptr;
        n_k         = r_k;
        n_taps      = r_taps;
        n_rd_v      = issue;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        if (out_beat) begin
            n_out_valid = 1'b0;
        end
        if (i_cfg_we) begin
            n_tap_count = i_cfg_wdata;
        end

        case (r_state)
            ST_CLEAR: begin
                n_clr_cnt = r_clr_cnt + 1'b1;
                if (r_clr_cnt == CLW'(CLR_LEN - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (push_beat) begin
                    // The newest sample is the first tap; older samples
                    // follow downward around the ring.
                    n_state  = ST_RUN;
                    n_rd_ptr = r_wr_pos;
                    n_k      = '0;
                    n_taps   = (r_tap_count > TAP_RESET) ? TAP_RESET : r_tap_count;
                end
            end
            ST_RUN: begin
                if (issue) begin
                    n_k      = r_k + 1'b1;
                    n_rd_ptr = r_rd_ptr - 1'b1;
                end
                // The result waits here if the previous one has not left
                // the output register.
                if (done && !r_out_valid) begin
                    n_out_valid = 1'b1;
                    n_out_data  = mac_stat.acc;
                    n_wr_pos    = r_wr_pos + 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_cnt   <= '0;
            r_tap_count <= TAP_RESET;
            r_wr_pos    <= '0;
            r_k         <= '0;
            r_taps      <= '0;
            r_rd_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_tap_count <= n_tap_count;
            r_wr_pos    <= n_wr_pos;
            r_k         <= n_k;
            r_taps      <= n_taps;
            r_rd_v      <= n_rd_v;
            r_out_valid <= n_out_valid;
        end
        r_rd_ptr   <= n_rd_ptr;
        r_out_data <= n_out_data;
    end

    assign o_out_ch.valid    = r_out_valid;
    assign o_out_ch.filtered = r_out_data;
endmodule

// ===== rtl/cbf_ram.sv =====
// ----------------------------------------------------------------------------
// cbf_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module cbf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/cbf_mac.sv =====
// ----------------------------------------------------------------------------
// cbf_mac: multiply-accumulate unit
// Registers the product of a sample and a coefficient, then adds it into
// a full-precision accumulator.
// ----------------------------------------------------------------------------
module cbf_mac (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cbf_pkg::t_mac_ctrl                  i_ctrl,
    input  logic signed [cbf_pkg::SAMPLE_W-1:0] i_sample,
    input  logic signed [cbf_pkg::SAMPLE_W-1:0] i_coef,
    output cbf_pkg::t_mac_stat                  o_stat
);
    import cbf_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_prod_v;
    logic signed [ACC_W-1:0]  r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_v <= 1'b0;
            r_acc    <= '0;
        end else begin
            r_prod_v <= i_ctrl.valid;
            if (i_ctrl.clear) begin
                r_acc <= '0;
            end else if (r_prod_v) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
        r_prod <= i_sample * i_coef;
    end

    assign o_stat.busy = r_prod_v;
    assign o_stat.acc  = r_acc;
endmodule

// ===== rtl/cbf_checker.sv =====
// ----------------------------------------------------------------------------
// cbf_checker: port-level checks for the circular buffer FIR filter
// Watches the channels of the top level and is attached to it by a bind.
// ----------------------------------------------------------------------------
module cbf_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            i_in_ready,
    input logic                            i_in_operation,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic [cbf_pkg::ACC_W-1:0]       i_out_filtered
);
    import cbf_pkg::*;

    // A result beat that is stalled keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_filtered)))
        else $error("stalled result beat changed");

    // The memories are swept after reset, so no item is taken right away.
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("input ready during reset sweep");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // A push holds off further beats while its taps are summed, and its
    // result cannot appear in the very next cycle.
    a_push_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && (i_in_operation == OP_PUSH))
            |=> (!i_in_ready && !$rose(i_out_valid)))
        else $error("input taken or result shown right after a push");
endmodule

bind circular_buffer_fir_filter_unit cbf_checker u_cbf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_ch.valid),
    .i_in_ready     (i_in_ch.ready),
    .i_in_operation (i_in_ch.operation),
    .i_out_valid    (o_out_ch.valid),
    .i_out_ready    (o_out_ch.ready),
    .i_out_filtered (o_out_ch.filtered)
);

// ===== verif/circular_buffer_fir_filter_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circular_buffer_fir_filter_unit_tb: self-checking bench of the FIR filter
// Drives coefficient loads, sample pushes and tap-count writes into the
// filter, predicts each filtered value with a behavioral copy of the sample
// ring and coefficient store, and compares every output beat in order. A
// short directed table runs first; random phases with varied tap counts and
// handshake idling follow.
// ----------------------------------------------------------------------------
module circular_buffer_fir_filter_unit_tb;
    import cbf_pkg::*;

    localparam int RING_DEPTH = 512;
    localparam int RING_AW    = $clog2(RING_DEPTH);

    // A push holds the block for at most the full 512 taps; a little margin is
    // added before any tap-count write and before the final verdict.
    localparam int BUSY_CYCLES = COEF_DEPTH + 8;

    // The longest silent stretch of a correct run is the reset sweep, a settling wait
    // or one full-length push plus a receiver stall. This limit is several times that.
    localparam int WATCHDOG_LIMIT = 4000;

    // Kinds of rows in the directed table.
    typedef enum logic {
        ROW_BEAT,
        ROW_TAPS
    } t_row_kind;

    // One row of the directed table. When has_sum is set, sum is the value
    // typed in by hand; otherwise the predictor supplies the expectation.
    typedef struct {
        t_row_kind               kind;
        logic [TAP_W-1:0]        taps;
        logic                    op;
        logic [COEF_AW-1:0]      idx;
        logic signed [SAMPLE_W-1:0] cval;
        logic signed [SAMPLE_W-1:0] smp;
        logic                    has_sum;
        logic signed [ACC_W-1:0] sum;
    } t_dir_row;

    // One random phase: tap count, number of beats and idling percentages.
    typedef struct {
        logic [TAP_W-1:0] taps;
        int               beats;
        int               send_pct;
        int               recv_pct;
        bit               pause_mid;
    } t_phase;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [TAP_W-1:0] i_cfg_wdata;

    cbf_in_if  in_ch ();
    cbf_out_if out_ch ();

    circular_buffer_fir_filter_unit #(
        .RING_DEPTH (RING_DEPTH)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_ch     (in_ch),
        .o_out_ch    (out_ch)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Behavioral copy of the filter state, updated as beats are accepted.
    // ------------------------------------------------------------------------
    logic signed [SAMPLE_W-1:0] ring_copy [RING_DEPTH];
    logic signed [SAMPLE_W-1:0] coef_copy [COEF_DEPTH];
    logic [RING_AW-1:0]         wr_pos;
    logic [TAP_W-1:0]           tap_setting;

    // Filtered values still owed by the block, oldest first.
    logic signed [ACC_W-1:0] pending_sums [$];

    int error_count    = 0;
    int idle_cycles    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // Store the new sample at the write position, sum the taps over the
    // ring going backward from it, then move the write position on.
    // Tap counts above the store depth are clamped; ring reads wrap.
    function automatic logic signed [ACC_W-1:0] fir_push(
        input logic signed [SAMPLE_W-1:0] smp
    );
        int unsigned                taps;
        logic [RING_AW-1:0]         pos;
        logic signed [PROD_W-1:0]   prod;
        logic signed [ACC_W-1:0]    acc;
        ring_copy[wr_pos] = smp;
        taps = (tap_setting > COEF_DEPTH) ? COEF_DEPTH : tap_setting;
        acc = '0;
        for (int k = 0; k < taps; k++) begin
            pos  = wr_pos - RING_AW'(k);
            prod = ring_copy[pos] * coef_copy[k];
            acc  = acc + prod;
        end
        wr_pos = wr_pos + 1'b1;
        return acc;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        error_count++;
    endtask

    // ------------------------------------------------------------------------
    // Output side: random back-pressure, in-order checking, and the count of
    // cycles without any handshake for the watchdog.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        logic in_beat;
        logic out_beat;
        logic signed [ACC_W-1:0] want;
        in_beat  = (in_ch.valid === 1'b1) && (in_ch.ready === 1'b1);
        out_beat = i_rst_n && (out_ch.valid === 1'b1) && (out_ch.ready === 1'b1);
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        if (out_beat) begin
            if (pending_sums.size() == 0) begin
                report_mismatch($sformatf("filtered %0d arrived with nothing pending",
                                          out_ch.filtered));
            end else begin
                want = pending_sums.pop_front();
                if (out_ch.filtered !== want) begin
                    report_mismatch($sformatf("filtered: expected %0d, got %0d",
                                              want, out_ch.filtered));
                end
            end
        end
        if (in_beat || out_beat) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // The watchdog ends the run if handshakes stop for too long.
    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Input side.
    // ------------------------------------------------------------------------

    // Present one beat after a random idle gap and wait until it is taken.
    // Valid is left high on return, so the caller must present the next beat
    // or lower valid in the same time step. On acceptance the model is
    // updated; a push queues either the hand-typed or the predicted sum.
    task automatic send_beat(
        input logic                    op,
        input logic [COEF_AW-1:0]      idx,
        input logic signed [SAMPLE_W-1:0] cval,
        input logic signed [SAMPLE_W-1:0] smp,
        input logic                    has_sum,
        input logic signed [ACC_W-1:0] sum
    );
        logic signed [ACC_W-1:0] model_sum;
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.operation   <= op;
        in_ch.coeff_index <= idx;
        in_ch.coeff_value <= cval;
        in_ch.sample      <= smp;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
        if (op == OP_PUSH) begin
            model_sum = fir_push(smp);
            pending_sums.push_back(has_sum ? sum : model_sum);
        end else begin
            coef_copy[idx] = cval;
        end
    endtask

    // Stop sending, let every owed result drain, then give the block time to
    // finish anything that produces no result before touching the register.
    task automatic settle_block();
        in_ch.valid <= 1'b0;
        while (pending_sums.size() != 0) @(posedge i_clk);
        repeat (BUSY_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_taps(input logic [TAP_W-1:0] taps);
        settle_block();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= taps;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        tap_setting = taps;
    endtask

    // Mostly random words, with the sign extremes, zero and minus one mixed in.
    function automatic logic signed [SAMPLE_W-1:0] pick_word();
        case ($urandom_range(11))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return 16'sh0000;
            3:       return 16'shffff;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Random beat shaped by the tap count: most loads land on taps that are
    // actually summed, so pushes see live coefficients.
    task automatic send_random_beat();
        int unsigned             eff_taps;
        logic                    op;
        logic [COEF_AW-1:0]      idx;
        eff_taps = (tap_setting > COEF_DEPTH) ? COEF_DEPTH : tap_setting;
        op = ($urandom_range(3) == 0) ? OP_LOAD : OP_PUSH;
        if (eff_taps != 0 && $urandom_range(3) != 0) begin
            idx = COEF_AW'($urandom_range(eff_taps - 1));
        end else begin
            idx = COEF_AW'($urandom);
        end
        send_beat(op, idx, pick_word(), pick_word(), 1'b0, '0);
    endtask

    // Directed table. Hand-typed sums appear only where the result is plain:
    // all-zero coefficients, a lone non-zero coefficient, zero taps, and single-tap extremes.
    t_dir_row dir_rows [] = '{
        // Fresh after reset: every coefficient is zero. Unused load fields
        // carry extreme values that must be ignored.
        '{ROW_BEAT, '0, OP_PUSH, 9'h1ff, 16'sh8000, 16'sh1234, 1'b1, 41'sd0},
        '{ROW_BEAT, '0, OP_PUSH, 9'h000, 16'sh7fff, 16'shffff, 1'b1, 41'sd0},
        // Most negative coefficient at tap 0; the sample field is ignored.
        '{ROW_BEAT, '0, OP_LOAD, 9'h000, 16'sh8000, 16'sh7fff, 1'b0, '0},
        '{ROW_BEAT, '0, OP_PUSH, 9'h0aa, 16'sh5555, 16'sh8000, 1'b1,
          41'sd1073741824},
        // Last tap and ring wrap-around over the full 512 taps.
        '{ROW_BEAT, '0, OP_LOAD, 9'h1ff, 16'sh7fff, 16'sh0000, 1'b0, '0},
        '{ROW_BEAT, '0, OP_PUSH, 9'h155, 16'shaaaa, 16'sh7fff, 1'b0, '0},
        '{ROW_BEAT, '0, OP_LOAD, 9'h001, 16'sh7fff, 16'sh5555, 1'b0, '0},
        '{ROW_BEAT, '0, OP_LOAD, 9'h002, 16'shffff, 16'shaaaa, 1'b0, '0},
        '{ROW_BEAT, '0, OP_LOAD, 9'h155, 16'sh5555, 16'shaaaa, 1'b0, '0},
        '{ROW_BEAT, '0, OP_LOAD, 9'h0aa, 16'shaaaa, 16'sh5555, 1'b0, '0},
        '{ROW_BEAT, '0, OP_PUSH, 9'h1ff, 16'sh8000, 16'sh0000, 1'b0, '0},
        // Zero taps: nothing is summed.
        '{ROW_TAPS, 10'd0, OP_PUSH, '0, '0, '0, 1'b0, '0},
        '{ROW_BEAT, '0, OP_PUSH, 9'h000, 16'sh0000, 16'sh3039, 1'b1, 41'sd0},
        // One tap: only the newest sample times the tap 0 coefficient.
        '{ROW_TAPS, 10'd1, OP_PUSH, '0, '0, '0, 1'b0, '0},
        '{ROW_BEAT, '0, OP_PUSH, 9'h000, 16'sh0000, 16'sh8000, 1'b1,
          41'sd1073741824},
        '{ROW_BEAT, '0, OP_PUSH, 9'h000, 16'sh0000, 16'sh7fff, 1'b1,
          -41'sd1073709056},
        // Too many taps: the widest setting behaves as 512.
        '{ROW_TAPS, 10'd1023, OP_PUSH, '0, '0, '0, 1'b0, '0},
        '{ROW_BEAT, '0, OP_PUSH, 9'h000, 16'sh0000, 16'shffff, 1'b0, '0},
        '{ROW_TAPS, 10'd512, OP_PUSH, '0, '0, '0, 1'b0, '0},
        '{ROW_BEAT, '0, OP_PUSH, 9'h000, 16'sh0000, 16'sh0064, 1'b0, '0},
        '{ROW_BEAT, '0, OP_LOAD, 9'h1ff, 16'sh8000, 16'sh0000, 1'b0, '0},
        '{ROW_BEAT, '0, OP_PUSH, 9'h000, 16'sh0000, 16'sh8000, 1'b0, '0}
    };

    // Random phases. Long tap counts are slow, so they get few beats; the
    // bulk of the traffic runs with short filters. Idling covers no idling,
    // a sluggish sender, a stalling receiver and both at once.
    t_phase phases [] = '{
        '{10'd8,    160, 0,  0,  1'b0},
        '{10'd1,    120, 58, 0,  1'b0},
        '{10'd23,   150, 0,  58, 1'b0},
        '{10'd0,     60, 10, 10, 1'b0},
        '{10'd1023,  25, 58, 0,  1'b0},
        '{10'd512,   35, 0,  58, 1'b0},
        '{10'd40,   200, 10, 10, 1'b1},
        '{10'd3,    150, 0,  0,  1'b0}
    };

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        // Every input known from time zero; reset held low at the start.
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = '0;
        in_ch.valid       = 1'b0;
        in_ch.operation   = OP_LOAD;
        in_ch.coeff_index = '0;
        in_ch.coeff_value = '0;
        in_ch.sample      = '0;
        foreach (ring_copy[i]) ring_copy[i] = '0;
        foreach (coef_copy[i]) coef_copy[i] = '0;
        wr_pos      = '0;
        tap_setting = TAP_RESET;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, full speed on both sides.
        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_TAPS) begin
                set_taps(dir_rows[r].taps);
            end else begin
                send_beat(dir_rows[r].op, dir_rows[r].idx, dir_rows[r].cval,
                          dir_rows[r].smp, dir_rows[r].has_sum, dir_rows[r].sum);
            end
        end

        // Random phases; each starts with a tap-count write on an idle block.
        foreach (phases[p]) begin
            set_taps(phases[p].taps);
            send_idle_pct  = phases[p].send_pct;
            recv_stall_pct = phases[p].recv_pct;
            for (int n = 0; n < phases[p].beats; n++) begin
                // Halfway through a marked phase the sender holds off until
                // every owed result has come back.
                if (phases[p].pause_mid && n == phases[p].beats / 2) begin
                    settle_block();
                end
                send_random_beat();
            end
        end

        // Drain, allow the last push to finish, and give the verdict.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        settle_block();
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
